// ===== rtl/pce_pkg.sv =====
// Shared types, codes and bit helpers for the programmable CRC engine.
`timescale 1ns / 1ps

package pce_pkg;

  localparam int CRC_W = 32;

  // request action codes
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_RESUME = 2'd1;
  localparam logic [1:0] ACT_BYTE   = 2'd2;

  // width select codes
  localparam logic [1:0] WSEL_32 = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_8  = 2'd2;
  localparam logic [1:0] WSEL_7  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH_SEL   = 3'd0;
  localparam logic [2:0] CFG_POLYNOMIAL  = 3'd1;
  localparam logic [2:0] CFG_INIT_VALUE  = 3'd2;
  localparam logic [2:0] CFG_XOR_OUT     = 3'd3;
  localparam logic [2:0] CFG_REFLECT_IN  = 3'd4;
  localparam logic [2:0] CFG_REFLECT_OUT = 3'd5;

  localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] ONES       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       width_sel;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] xor_out;
    logic             reflect_in;
    logic             reflect_out;
  } pce_cfg_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] sel);
    logic [CRC_W-1:0] m;
    case (sel)
      WSEL_32: m = 32'hFFFF_FFFF;
      WSEL_16: m = 32'h0000_FFFF;
      WSEL_8:  m = 32'h0000_00FF;
      WSEL_7:  m = 32'h0000_007F;
      default: m = 32'h0000_007F;
    endcase
    return m;
  endfunction

  // top bit of the register at the selected width
  function automatic logic width_msb(input logic [CRC_W-1:0] c, input logic [1:0] sel);
    logic b;
    case (sel)
      WSEL_32: b = c[31];
      WSEL_16: b = c[15];
      WSEL_8:  b = c[7];
      WSEL_7:  b = c[6];
      default: b = c[6];
    endcase
    return b;
  endfunction

  // bit reversal across the selected width; bits above the width come out zero
  function automatic logic [CRC_W-1:0] reverse_width(input logic [CRC_W-1:0] v,
                                                     input logic [1:0] sel);
    logic [CRC_W-1:0] r;
    r = '0;
    case (sel)
      WSEL_32: for (int i = 0; i < 32; i++) r[i] = v[31-i];
      WSEL_16: for (int i = 0; i < 16; i++) r[i] = v[15-i];
      WSEL_8:  for (int i = 0; i < 8; i++)  r[i] = v[7-i];
      WSEL_7:  for (int i = 0; i < 7; i++)  r[i] = v[6-i];
      default: for (int i = 0; i < 7; i++)  r[i] = v[6-i];
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pce_step.sv =====
// Next CRC register value for one request: load init, load resume value or shift a byte.
`timescale 1ns / 1ps

module pce_step (
  input  pce_pkg::pce_cfg_t            cfg,
  input  logic [1:0]                   action,
  input  logic [7:0]                   data_byte,
  input  logic [pce_pkg::CRC_W-1:0]    resume_value,
  input  logic [pce_pkg::CRC_W-1:0]    crc_cur,
  output logic [pce_pkg::CRC_W-1:0]    crc_next
);
  import pce_pkg::*;

  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] poly;
  logic [CRC_W-1:0] shift_c;
  logic [7:0]       byte_in;
  logic             fb;

  assign mask = width_mask(cfg.width_sel);
  assign poly = cfg.polynomial & mask;

  always_comb begin
    for (int i = 0; i < 8; i++) byte_in[i] = cfg.reflect_in ? data_byte[7-i] : data_byte[i];
  end

  // eight MSB-first shift steps, unrolled
  always_comb begin
    shift_c = crc_cur & mask;
    fb      = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      fb      = width_msb(shift_c, cfg.width_sel) ^ byte_in[i];
      shift_c = (shift_c << 1) & mask;
      if (fb) shift_c = shift_c ^ poly;
    end
  end

  always_comb begin
    case (action)
      ACT_START:  crc_next = cfg.init_value & mask;
      ACT_RESUME: crc_next = cfg.reflect_out ? reverse_width(resume_value & mask, cfg.width_sel)
                                             : (resume_value & mask);
      ACT_BYTE:   crc_next = shift_c;
      default:    crc_next = crc_cur;  // unused code leaves the register alone
    endcase
  end

endmodule

// ===== rtl/pce_finish.sv =====
// Finished CRC value: mask, optional reflection across the width, output XOR.
`timescale 1ns / 1ps

module pce_finish (
  input  pce_pkg::pce_cfg_t            cfg,
  input  logic [pce_pkg::CRC_W-1:0]    crc_reg,
  output logic [pce_pkg::CRC_W-1:0]    crc_value
);
  import pce_pkg::*;

  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] masked;
  logic [CRC_W-1:0] oriented;

  assign mask      = width_mask(cfg.width_sel);
  assign masked    = crc_reg & mask;
  assign oriented  = cfg.reflect_out ? reverse_width(masked, cfg.width_sel) : masked;
  assign crc_value = (oriented ^ cfg.xor_out) & mask;

endmodule

// ===== rtl/programmable_crc_engine.sv =====
// Top level of the programmable CRC engine: config registers, request stage, result stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | in_action, in_data_byte, in_resume_value
//  out     | output    | out_valid/out_stall| out_crc_value
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall stays low; a taken request reaches out_valid
// through the request register, then the result register behind the 8-step shift.
// The CRC register and result register update together in the same cycle.
// Synchronous active-low reset: config back to defaults, CRC register all ones,
// both stages empty. A stalled result holds the result stage; the request stage keeps
// taking requests until it holds one that cannot move, then in_stall goes high.
`timescale 1ns / 1ps

module programmable_crc_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [7:0]                    in_data_byte,
  input  logic [pce_pkg::CRC_W-1:0]     in_resume_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pce_pkg::CRC_W-1:0]     out_crc_value,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [pce_pkg::CRC_W-1:0]     cfg_wdata
);
  import pce_pkg::*;

  pce_cfg_t         cfg_r;
  logic             req_valid_r;
  logic [1:0]       req_action_r;
  logic [7:0]       req_byte_r;
  logic [CRC_W-1:0] req_resume_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic             out_valid_r;
  logic [CRC_W-1:0] out_crc_r;
  logic [CRC_W-1:0] out_crc_nxt;
  logic             advance;
  logic             fire;
  logic             in_take;

  // result stage can load when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = req_valid_r && advance;
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_sel   <= WSEL_32;
      cfg_r.polynomial  <= POLY_RESET;
      cfg_r.init_value  <= ONES;
      cfg_r.xor_out     <= '0;
      cfg_r.reflect_in  <= 1'b0;
      cfg_r.reflect_out <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_SEL:   cfg_r.width_sel   <= cfg_wdata[1:0];
        CFG_POLYNOMIAL:  cfg_r.polynomial  <= cfg_wdata;
        CFG_INIT_VALUE:  cfg_r.init_value  <= cfg_wdata;
        CFG_XOR_OUT:     cfg_r.xor_out     <= cfg_wdata;
        CFG_REFLECT_IN:  cfg_r.reflect_in  <= cfg_wdata[0];
        CFG_REFLECT_OUT: cfg_r.reflect_out <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_action_r <= in_action;
      req_byte_r   <= in_data_byte;
      req_resume_r <= in_resume_value;
    end
  end

  pce_step u_step (
    .cfg          (cfg_r),
    .action       (req_action_r),
    .data_byte    (req_byte_r),
    .resume_value (req_resume_r),
    .crc_cur      (crc_r),
    .crc_next     (crc_nxt)
  );

  pce_finish u_finish (
    .cfg       (cfg_r),
    .crc_reg   (crc_nxt),
    .crc_value (out_crc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= ONES;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) crc_r <= crc_nxt;
      if (advance) out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_crc_r <= out_crc_nxt;
  end

`ifndef SYNTH
  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(req_valid_r))
    else $error("result appeared without a pending request");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_valid_r)
    else $error("input stalled with empty request stage");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !req_valid_r) |=> !out_valid_r)
    else $error("result stage kept a delivered result");

  a_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(crc_r))
    else $error("CRC register changed without a request");
`endif

endmodule
